// ----- hw/rtl/bidq_pkg.sv -----
// shared constants, codes and types of the bounded id queue
`default_nettype none
package bidq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 31;
    localparam int TOK_W       = 8;
    localparam int OUT_CNT_W   = 8;

    localparam logic [TOK_W-1:0] BUDGET_RESET = TOK_W'(100);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SERVE,
        OP_REMOVE,
        OP_NOP
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_FULL,
        ST_DUP,
        ST_EMPTY,
        ST_NOTOK,
        ST_NOTFOUND,
        ST_INVALID
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD_RD,
        S_HEAD_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [ID_W-1:0]       wr_data;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                  done;
        status_t               status;
        logic [ID_W-1:0]       served_id;
        logic [CNT_W-1:0]      count;
        logic [TOK_W-1:0]      tokens_left;
    } result_t;

    // circular slot of an offset from the head
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + (ADDR_W+1)'(offset[ADDR_W-1:0]);
        if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] res;
        if (head == ADDR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = head + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bidq_store.sv -----
// id storage ram, one write and one registered read per cycle
`default_nettype none
module bidq_store
    import bidq_pkg::*;
(
    input  wire logic            aclk,
    input  wire mem_req_t        req,
    output logic [ID_W-1:0]      rd_data
);

    logic [ID_W-1:0] mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[req.rd_addr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bidq_ctrl.sv -----
// sequencer: search, shift, serve and queue bookkeeping
`default_nettype none
module bidq_ctrl
    import bidq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [1:0]        in_op,
    input  wire logic [ID_W-1:0]   in_id,
    input  wire logic [TOK_W-1:0]  budget,
    input  wire logic              out_free,
    input  wire logic [ID_W-1:0]   rd_data,
    output logic                   idle,
    output mem_req_t               mem_req,
    output result_t                res
);

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOK_W-1:0]  used_reg, used_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   served_reg, served_next;

    logic [TOK_W-1:0]  tokens_left;
    logic [CNT_W-1:0]  k_inc;
    logic              add_full;
    logic              match;
    logic              last;
    opcode_t           in_opc;

    assign in_opc      = opcode_t'(in_op);
    assign tokens_left = (budget > used_reg) ? budget - used_reg : '0;
    assign k_inc       = k_reg + CNT_W'(1);
    assign add_full    = (count_reg >= tokens_left) || (count_reg == CNT_W'(QUEUE_DEPTH));
    assign match       = (rd_data == id_reg);
    assign last        = (k_inc == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        served_reg <= served_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (in_opc)
                        OP_ADD: begin
                            if (add_full || in_id == '0 || count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_SERVE: begin
                            if (count_reg == '0 || tokens_left == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_HEAD_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (in_id == '0 || count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_FIND_RD: state_next = S_FIND_CMP;
            S_FIND_CMP: begin
                if (match) begin
                    if (op_reg == OP_REMOVE && k_reg != '0) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (last) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FIND_RD;
                end
            end
            S_SHIFT_RD: begin
                if (k_inc < count_reg) begin
                    state_next = S_SHIFT_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR:  state_next = S_SHIFT_RD;
            S_HEAD_RD:   state_next = S_HEAD_DATA;
            S_HEAD_DATA: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next          = op_reg;
        id_next          = id_reg;
        k_next           = k_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        used_next        = used_reg;
        status_next      = status_reg;
        served_next      = served_reg;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = slot_of(head_reg, count_reg);
        mem_req.wr_data  = id_reg;
        mem_req.rd_addr  = slot_of(head_reg, k_reg);
        idle             = 1'b0;
        res.done         = 1'b0;
        res.status       = status_reg;
        res.served_id    = served_reg;
        res.count        = count_reg;
        res.tokens_left  = tokens_left;

        unique case (state_reg)
            S_IDLE: begin
                idle = 1'b1;
                if (in_fire) begin
                    op_next     = in_opc;
                    id_next     = in_id;
                    k_next      = '0;
                    served_next = '0;
                    status_next = ST_OK;
                    unique case (in_opc)
                        OP_ADD: begin
                            if (add_full) begin
                                status_next = ST_FULL;
                            end else if (in_id == '0) begin
                                status_next = ST_INVALID;
                            end else if (count_reg == '0) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_data = in_id;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        OP_SERVE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (tokens_left == '0) begin
                                status_next = ST_NOTOK;
                            end
                        end
                        OP_REMOVE: begin
                            if (in_id == '0) begin
                                status_next = ST_INVALID;
                            end else if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end
            S_FIND_RD: begin
                mem_req.rd_addr = slot_of(head_reg, k_reg);
            end
            S_FIND_CMP: begin
                if (match) begin
                    if (op_reg == OP_ADD) begin
                        status_next = ST_DUP;
                    end else if (k_reg == '0) begin
                        head_next  = next_slot(head_reg);
                        count_next = count_reg - CNT_W'(1);
                    end
                end else begin
                    k_next = k_inc;
                    if (last) begin
                        if (op_reg == OP_ADD) begin
                            mem_req.wr_en = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                        end else begin
                            status_next = ST_NOTFOUND;
                        end
                    end
                end
            end
            S_SHIFT_RD: begin
                mem_req.rd_addr = slot_of(head_reg, k_inc);
                if (!(k_inc < count_reg)) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_SHIFT_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot_of(head_reg, k_reg);
                mem_req.wr_data = rd_data;
                k_next          = k_inc;
            end
            S_HEAD_RD: begin
                mem_req.rd_addr = head_reg;
            end
            S_HEAD_DATA: begin
                served_next = rd_data;
                head_next   = next_slot(head_reg);
                count_next  = count_reg - CNT_W'(1);
                used_next   = used_reg + TOK_W'(1);
            end
            S_DONE: begin
                res.done = 1'b1;
            end
            default: idle = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bounded_id_queue_with_budget.sv -----
// top level: fifo of ids with keyed removal, gated by a token budget
//
// input channel s_*: one beat carries an opcode (add, serve, remove, nop) and an id.
// result channel m_*: one beat per input beat with status, served id, the
// waiting count and the tokens left after the operation.
// cfg_*: writes the token budget; take it only while the block is idle.
// sequence: rejected or trivial requests go straight to the result; a serve
// reads the head entry and then takes its data; add and remove search the ids
// entry by entry; a remove then moves each later entry down to close the gap.
// the registered read of the id ram is why each entry is first read and then,
// in a state of its own, compared or written to its new slot.
// one request is in work at a time; s_ready is high only while the sequencer
// is idle. a finished result sits in the output register, so a new request is
// taken while the receiver stalls; the following result waits until it drains.
// reset (synchronous, active low) empties the queue, clears tokens used and
// sets the budget to 100; the ram contents are not cleared.
`default_nettype none
module bounded_id_queue_with_budget
    import bidq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_opcode,
    input  wire logic [ID_W-1:0]       s_item_id,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_status,
    output logic [ID_W-1:0]            m_served_id,
    output logic [OUT_CNT_W-1:0]       m_waiting_count,
    output logic [TOK_W-1:0]           m_tokens_left,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [TOK_W-1:0]      cfg_data
);

    logic [TOK_W-1:0]     budget_reg;
    logic                 m_valid_reg;
    logic [2:0]           status_reg;
    logic [ID_W-1:0]      served_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [TOK_W-1:0]     tokens_reg;

    logic                 idle;
    logic                 out_free;
    logic                 in_fire;
    mem_req_t             mem_req;
    result_t              res;
    logic [ID_W-1:0]      rd_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign in_fire   = s_valid && idle;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= BUDGET_RESET;
        end else if (cfg_valid) begin
            budget_reg <= cfg_data;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.done && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done && out_free) begin
            status_reg <= res.status;
            served_reg <= res.served_id;
            count_reg  <= OUT_CNT_W'(res.count);
            tokens_reg <= res.tokens_left;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_served_id     = served_reg;
    assign m_waiting_count = count_reg;
    assign m_tokens_left   = tokens_reg;

    bidq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_op    (s_opcode),
        .in_id    (s_item_id),
        .budget   (budget_reg),
        .out_free (out_free),
        .rd_data  (rd_data),
        .idle     (idle),
        .mem_req  (mem_req),
        .res      (res)
    );

    bidq_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire
